// ===== design/bf3_pkg.sv =====
// shared constants and types of the 3x3 box filter
package bf3_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // samples in one neighbourhood
  localparam int KERNEL_COUNT = 9;

  // fixed tag and register widths
  localparam int ROW_BITS          = 16;
  localparam int COL_TAG_BITS      = 10;
  localparam int FRAME_WIDTH_BITS  = 11;
  localparam int FRAME_HEIGHT_BITS = 16;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 16;

  localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 16'd1024;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // result slots one input word can release, in output order
  localparam int NUM_RES       = 4;
  localparam int RES_CENTER    = 0;  // pixel one row up, one column left
  localparam int RES_ROW_END   = 1;  // pixel one row up, last column
  localparam int RES_LAST_ROW  = 2;  // last row, one column left
  localparam int RES_FRAME_END = 3;  // last pixel of the frame

  // per-word control carried down the pipeline
  typedef struct packed {
    logic                interior;
    logic [NUM_RES-1:0]  emit;
  } res_flags_t;

endpackage

// ===== design/bf3_sample_if.sv =====
// input word channel: one height sample per word
interface bf3_sample_if #(
  parameter int SAMPLE_BITS = bf3_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/bf3_result_if.sv =====
// result word channel: smoothed value with its pixel position
interface bf3_result_if #(
  parameter int SAMPLE_BITS = bf3_pkg::DEF_SAMPLE_BITS
);
  logic                                 valid;
  logic                                 ready;
  logic signed [SAMPLE_BITS-1:0]        value;
  logic [bf3_pkg::ROW_BITS-1:0]         out_row;
  logic [bf3_pkg::COL_TAG_BITS-1:0]     out_col;
  logic                                 frame_end;

  modport source (output valid, output value, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink   (input valid, input value, input out_row, input out_col,
                  input frame_end, output ready);
endinterface

// ===== design/bf3_cfg_if.sv =====
// configuration write channel
interface bf3_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [bf3_pkg::CFG_INDEX_BITS-1:0]   index;
  logic [bf3_pkg::CFG_DATA_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/bf3_ram.sv =====
// generic single write port ram with registered read
module bf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the contents before a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== design/bf3_front.sv =====
// position counters, line store, window and nine-sample sum
module bf3_front #(
  parameter int MAX_WIDTH   = bf3_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = bf3_pkg::DEF_SAMPLE_BITS,
  localparam int CW       = $clog2(MAX_WIDTH),
  localparam int SUM_BITS = SAMPLE_BITS + 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [CW-1:0]                       wlast,
  input  logic [bf3_pkg::ROW_BITS-1:0]        hlast,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output logic                                f_valid,
  input  logic                                f_ready,
  output logic signed [SUM_BITS-1:0]          f_sum,
  output logic signed [SAMPLE_BITS-1:0]       f_sample,
  output logic signed [SAMPLE_BITS-1:0]       f_mid,
  output logic signed [SAMPLE_BITS-1:0]       f_center,
  output logic signed [SAMPLE_BITS-1:0]       f_left,
  output logic [bf3_pkg::ROW_BITS-1:0]        f_row,
  output logic [CW-1:0]                       f_col,
  output bf3_pkg::res_flags_t                 f_flags
);
  import bf3_pkg::*;

  localparam int SB      = SAMPLE_BITS;
  localparam int CS_BITS = SAMPLE_BITS + 2;

  logic [CW-1:0]       col;
  logic [ROW_BITS-1:0] row;
  logic                row_end;
  logic                last_row;
  logic                accept;
  res_flags_t          flags_next;

  logic                   s1_valid;
  logic signed [SB-1:0]   s1_sample;
  logic [ROW_BITS-1:0]    s1_row;
  logic [CW-1:0]          s1_col;
  res_flags_t             s1_flags;
  logic                   s1_fire;

  logic                   fwd_hit;
  logic [2*SB-1:0]        fwd_data;
  logic [2*SB-1:0]        ram_rdata;
  logic [2*SB-1:0]        line;
  logic [2*SB-1:0]        line_wdata;
  logic signed [SB-1:0]   top;
  logic signed [SB-1:0]   mid;

  logic signed [SB-1:0]       prev_mid;
  logic signed [SB-1:0]       prev_sample;
  logic signed [CS_BITS-1:0]  cs0;
  logic signed [CS_BITS-1:0]  cs1;
  logic signed [CS_BITS-1:0]  cs_new;

  assign accept   = in_valid && in_ready;
  assign in_ready = !s1_valid || f_ready;
  assign s1_fire  = s1_valid && f_ready;

  // raster position of the incoming word
  assign row_end  = col >= wlast;
  assign last_row = row >= hlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (row_end) begin
        col <= '0;
        row <= last_row ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // which results this word releases
  always_comb begin
    flags_next = '0;
    flags_next.emit[RES_CENTER]    = (row != '0) && (col != '0);
    flags_next.emit[RES_ROW_END]   = (row != '0) && row_end;
    flags_next.emit[RES_LAST_ROW]  = last_row && (col != '0);
    flags_next.emit[RES_FRAME_END] = last_row && row_end;
    flags_next.interior = (row >= ROW_BITS'(2)) && (row <= hlast) &&
                          (col >= CW'(2)) && (col <= wlast);
  end

  // stage 1 holds the word while the line store read comes back
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
      if (accept) begin
        fwd_hit <= s1_fire && (s1_col == col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= in_sample;
      s1_row    <= row;
      s1_col    <= col;
      s1_flags  <= flags_next;
      fwd_data  <= line_wdata;
    end
  end

  // both line rows live in one word: upper half two rows up, lower half one row up
  bf3_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (line_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // forward the write that landed on the same column in the read cycle
  assign line       = fwd_hit ? fwd_data : ram_rdata;
  assign top        = line[2*SB-1:SB];
  assign mid        = line[SB-1:0];
  assign line_wdata = {mid, s1_sample};

  // window kept as two column sums plus the center and left samples
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mid    <= '0;
      prev_sample <= '0;
      cs0         <= '0;
      cs1         <= '0;
    end else if (s1_fire) begin
      prev_mid    <= mid;
      prev_sample <= s1_sample;
      cs0         <= cs_new;
      cs1         <= cs0;
    end
  end

  assign cs_new = CS_BITS'(top) + CS_BITS'(mid) + CS_BITS'(s1_sample);

  assign f_valid  = s1_valid;
  assign f_sum    = SUM_BITS'(cs_new) + SUM_BITS'(cs0) + SUM_BITS'(cs1);
  assign f_sample = s1_sample;
  assign f_mid    = mid;
  assign f_center = prev_mid;
  assign f_left   = prev_sample;
  assign f_row    = s1_row;
  assign f_col    = s1_col;
  assign f_flags  = s1_flags;
endmodule

// ===== design/bf3_back.sv =====
// rounded divide by nine and result sequencing onto the output register
module bf3_back #(
  parameter int MAX_WIDTH   = bf3_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = bf3_pkg::DEF_SAMPLE_BITS,
  localparam int CW       = $clog2(MAX_WIDTH),
  localparam int SUM_BITS = SAMPLE_BITS + 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                f_valid,
  output logic                                f_ready,
  input  logic signed [SUM_BITS-1:0]          f_sum,
  input  logic signed [SAMPLE_BITS-1:0]       f_sample,
  input  logic signed [SAMPLE_BITS-1:0]       f_mid,
  input  logic signed [SAMPLE_BITS-1:0]       f_center,
  input  logic signed [SAMPLE_BITS-1:0]       f_left,
  input  logic [bf3_pkg::ROW_BITS-1:0]        f_row,
  input  logic [CW-1:0]                       f_col,
  input  bf3_pkg::res_flags_t                 f_flags,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_value,
  output logic [bf3_pkg::ROW_BITS-1:0]        out_row,
  output logic [bf3_pkg::COL_TAG_BITS-1:0]    out_col,
  output logic                                out_frame_end
);
  import bf3_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  // rounded magnitude width, reciprocal shift and width
  localparam int N    = SAMPLE_BITS + 3;
  localparam int K    = N + 1;
  localparam int RW   = N - 2;
  localparam int H    = N / 2;
  localparam int HH   = N - H;
  localparam int PW   = N + RW;
  localparam int HALF = KERNEL_COUNT / 2;
  localparam logic [N+1:0]  POW_K      = {1'b1, {K{1'b0}}};
  localparam logic [N+1:0]  RECIP_FULL = POW_K / (N + 2)'(KERNEL_COUNT);
  localparam logic [RW-1:0] RECIP      = RECIP_FULL[RW-1:0];

  // shared payload of one word
  logic signed [SB-1:0] s2_sample, s3_sample, s4_sample;
  logic signed [SB-1:0] s2_mid, s3_mid, s4_mid;
  logic signed [SB-1:0] s2_center, s3_center, s4_center;
  logic signed [SB-1:0] s2_left, s3_left, s4_left;
  logic [ROW_BITS-1:0]  s2_row, s3_row, s4_row;
  logic [CW-1:0]        s2_col, s3_col, s4_col;
  res_flags_t           s2_flags, s3_flags;
  logic                 s4_interior;

  logic                        s2_valid, s3_valid;
  logic signed [SUM_BITS-1:0]  s2_sum;
  logic signed [SUM_BITS-1:0]  abs_sum;
  logic [N-1:0]                mag;
  logic [N-1:0]                m3, m4;
  logic                        neg3, neg4;
  logic [H+RW-1:0]             plo3;
  logic [HH+RW-1:0]            phi3;
  logic [PW-1:0]               prod;
  logic [SB-1:0]               q0_4;

  logic [N-1:0]          nine_q;
  logic [N-1:0]          rem;
  logic [SB:0]           quot;
  logic signed [SB-1:0]  mean;

  logic [NUM_RES-1:0]        pend;
  logic [NUM_RES-1:0]        pick;
  logic                      out_load;
  logic                      s4_free;
  logic                      s3_open;
  logic                      s3_move;
  logic signed [SB-1:0]      sel_value;
  logic [ROW_BITS-1:0]       sel_row;
  logic [COL_TAG_BITS-1:0]   sel_col;
  logic                      sel_end;

  // pipeline advance, back to front
  assign out_load = (pend != '0) && (!out_valid || out_ready);
  assign s4_free  = (pend == '0) || (out_load && ((pend & ~pick) == '0));
  assign s3_open  = !s3_valid || s4_free;
  assign s3_move  = s3_valid && s4_free;
  assign f_ready  = !s2_valid || s3_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (f_ready) begin
        s2_valid <= f_valid;
      end
      if (s3_open) begin
        s3_valid <= s2_valid;
      end
    end
  end

  // stage 2: registered sum
  always_ff @(posedge clk) begin
    if (f_ready && f_valid) begin
      s2_sum    <= f_sum;
      s2_sample <= f_sample;
      s2_mid    <= f_mid;
      s2_center <= f_center;
      s2_left   <= f_left;
      s2_row    <= f_row;
      s2_col    <= f_col;
      s2_flags  <= f_flags;
    end
  end

  // magnitude with half added, two partial products of the reciprocal
  assign abs_sum = (s2_sum < 0) ? -s2_sum : s2_sum;
  assign mag     = N'(abs_sum) + N'(HALF);

  always_ff @(posedge clk) begin
    if (s3_open && s2_valid) begin
      m3        <= mag;
      neg3      <= s2_sum < 0;
      plo3      <= (H + RW)'(mag[H-1:0]) * (H + RW)'(RECIP);
      phi3      <= (HH + RW)'(mag[N-1:H]) * (HH + RW)'(RECIP);
      s3_sample <= s2_sample;
      s3_mid    <= s2_mid;
      s3_center <= s2_center;
      s3_left   <= s2_left;
      s3_row    <= s2_row;
      s3_col    <= s2_col;
      s3_flags  <= s2_flags;
    end
  end

  // quotient estimate, at most one short of the true quotient
  assign prod = PW'(plo3) + (PW'(phi3) << H);

  always_ff @(posedge clk) begin
    if (s3_move) begin
      q0_4        <= prod[PW-1:K];
      m4          <= m3;
      neg4        <= neg3;
      s4_sample   <= s3_sample;
      s4_mid      <= s3_mid;
      s4_center   <= s3_center;
      s4_left     <= s3_left;
      s4_row      <= s3_row;
      s4_col      <= s3_col;
      s4_interior <= s3_flags.interior;
    end
  end

  // pending results of the word in stage 4
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (s4_free) begin
      pend <= s3_move ? s3_flags.emit : '0;
    end else if (out_load) begin
      pend <= pend & ~pick;
    end
  end

  // correct the estimate and restore the sign
  assign nine_q = N'({q0_4, 3'b000}) + N'(q0_4);
  assign rem    = m4 - nine_q;
  assign quot   = (SB + 1)'(q0_4) + (SB + 1)'(rem >= N'(KERNEL_COUNT));
  assign mean   = neg4 ? SB'(-quot) : SB'(quot);

  // lowest pending slot goes first
  always_comb begin
    pick      = '0;
    sel_value = s4_sample;
    sel_row   = s4_row;
    sel_col   = COL_TAG_BITS'(s4_col);
    sel_end   = 1'b0;
    if (pend[RES_CENTER]) begin
      pick[RES_CENTER] = 1'b1;
      sel_value        = s4_interior ? mean : s4_center;
      sel_row          = s4_row - 1'b1;
      sel_col          = COL_TAG_BITS'(s4_col - 1'b1);
    end else if (pend[RES_ROW_END]) begin
      pick[RES_ROW_END] = 1'b1;
      sel_value         = s4_mid;
      sel_row           = s4_row - 1'b1;
    end else if (pend[RES_LAST_ROW]) begin
      pick[RES_LAST_ROW] = 1'b1;
      sel_value          = s4_left;
      sel_col            = COL_TAG_BITS'(s4_col - 1'b1);
    end else if (pend[RES_FRAME_END]) begin
      pick[RES_FRAME_END] = 1'b1;
      sel_end             = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value     <= sel_value;
      out_row       <= sel_row;
      out_col       <= sel_col;
      out_frame_end <= sel_end;
    end
  end
endmodule

// ===== design/box_filter_3x3_mean.sv =====
// top level of the 3x3 mean filter over a raster height-map frame
// Takes one signed sample per word in raster order and returns each pixel as the
// rounded mean of its 3x3 neighbourhood (ties away from zero), border pixels
// unchanged, tagged with row and column; results lag the input by one row and one
// column, and words of the last row also flush that row, the final result carrying
// frame_end. A sample word is taken every cycle while the output is not stalled
// and each word releases at most one result; a word that ends a row below the
// first, or a word past the first column of the last row below the first, releases
// two (four at the frame's last pixel) and the input then waits while the extra
// results leave, since the output register moves one result per cycle when not
// stalled. A result passes the line store read, the registered sum, the divide by
// nine and the output register. Both rows above live in a single-port-write ram of
// MAX_WIDTH words; no clearing pass is needed after reset.
// Configuration is taken at any time but should only change between frames.
module box_filter_3x3_mean #(
  parameter int MAX_WIDTH   = bf3_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = bf3_pkg::DEF_SAMPLE_BITS
) (
  input  logic          clk,
  input  logic          rst,
  bf3_sample_if.sink    samples,
  bf3_result_if.source  results,
  bf3_cfg_if.sink       cfg
);
  import bf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = (CW + 1 > FRAME_WIDTH_BITS) ? CW + 1 : FRAME_WIDTH_BITS;
  localparam int SUM_BITS = SAMPLE_BITS + 4;

  logic [FRAME_WIDTH_BITS-1:0]  frame_width;
  logic [FRAME_HEIGHT_BITS-1:0] frame_height;
  logic [WB-1:0]                width_ext;
  logic [CW-1:0]                wlast;
  logic [ROW_BITS-1:0]          hlast;

  logic                          f_valid;
  logic                          f_ready;
  logic signed [SUM_BITS-1:0]    f_sum;
  logic signed [SAMPLE_BITS-1:0] f_sample;
  logic signed [SAMPLE_BITS-1:0] f_mid;
  logic signed [SAMPLE_BITS-1:0] f_center;
  logic signed [SAMPLE_BITS-1:0] f_left;
  logic [ROW_BITS-1:0]           f_row;
  logic [CW-1:0]                 f_col;
  res_flags_t                    f_flags;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_FRAME_WIDTH:  frame_width  <= cfg.data[FRAME_WIDTH_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg.data[FRAME_HEIGHT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // last column and last row, sizes clamped to the supported range
  assign width_ext = WB'(frame_width);

  always_comb begin
    if (frame_width == '0) begin
      wlast = '0;
    end else if (width_ext > WB'(MAX_WIDTH)) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(width_ext - 1'b1);
    end
  end

  assign hlast = (frame_height == '0) ? '0 : ROW_BITS'(frame_height - 1'b1);

  bf3_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .wlast     (wlast),
    .hlast     (hlast),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_sample (samples.sample),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_sum     (f_sum),
    .f_sample  (f_sample),
    .f_mid     (f_mid),
    .f_center  (f_center),
    .f_left    (f_left),
    .f_row     (f_row),
    .f_col     (f_col),
    .f_flags   (f_flags)
  );

  bf3_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .f_valid       (f_valid),
    .f_ready       (f_ready),
    .f_sum         (f_sum),
    .f_sample      (f_sample),
    .f_mid         (f_mid),
    .f_center      (f_center),
    .f_left        (f_left),
    .f_row         (f_row),
    .f_col         (f_col),
    .f_flags       (f_flags),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_value     (results.value),
    .out_row       (results.out_row),
    .out_col       (results.out_col),
    .out_frame_end (results.frame_end)
  );
endmodule

// ===== design/bf3_checker.sv =====
// port-level checks of the 3x3 mean filter, bound to the top level
module bf3_checker #(
  parameter int SAMPLE_BITS = bf3_pkg::DEF_SAMPLE_BITS
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [SAMPLE_BITS-1:0]             out_value,
  input logic [bf3_pkg::ROW_BITS-1:0]       out_row,
  input logic [bf3_pkg::COL_TAG_BITS-1:0]   out_col,
  input logic                               out_frame_end,
  input logic                               cfg_valid,
  input logic                               cfg_ready
);
  logic seen_in;

  // any sample word taken since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_in <= 1'b0;
    end else if (in_valid && in_ready) begin
      seen_in <= 1'b1;
    end
  end

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_row) &&
      $stable(out_col) && $stable(out_frame_end))
    else $error("stalled result changed");

  // no result without a sample behind it
  a_cause: assert property (@(posedge clk) disable iff (rst) out_valid |-> seen_in)
    else $error("result with no sample taken");

  // configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");
endmodule

bind box_filter_3x3_mean bf3_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bf3_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_value     (results.value),
  .out_row       (results.out_row),
  .out_col       (results.out_col),
  .out_frame_end (results.frame_end),
  .cfg_valid     (cfg.valid),
  .cfg_ready     (cfg.ready)
);

// ===== tb/tb_box_filter_3x3_mean.sv =====
// testbench for the 3x3 box mean filter: directed frames, then random frames checked by a predictor
module tb_box_filter_3x3_mean;
  timeunit 1ns;
  timeprecision 1ps;

  import bf3_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int RAND_WORDS    = 380;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 3000;

  // one smoothed pixel as it leaves the block
  typedef struct packed {
    logic signed [15:0]      value;
    logic [ROW_BITS-1:0]     row;
    logic [COL_TAG_BITS-1:0] col;
    logic                    frame_end;
  } pixel_t;

  // directed plan: a frame size change, or a run of identical sample words
  typedef enum int {ROW_SIZE, ROW_WORD} step_kind_t;
  typedef struct packed {
    step_kind_t         kind;
    int                 a;
    int                 b;
    int                 times;
    bit                 known;
    logic signed [15:0] want;
  } plan_row_t;

  // known value is the first result released by the last word of a run
  localparam plan_row_t PLAN [0:6] = '{
    '{ROW_SIZE, 3, 3, 1, 1'b0, 16'sh0000},
    '{ROW_WORD, 32767, 0, 8, 1'b0, 16'sh0000},
    '{ROW_WORD, 32767, 0, 1, 1'b1, 16'sh7FFF},
    '{ROW_WORD, -32768, 0, 8, 1'b0, 16'sh0000},
    '{ROW_WORD, -32768, 0, 1, 1'b1, 16'sh8000},
    '{ROW_SIZE, 0, 0, 1, 1'b0, 16'sh0000},
    '{ROW_WORD, 4660, 0, 1, 1'b1, 16'sh1234}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  bf3_sample_if #(.SAMPLE_BITS(16)) samp_ch ();
  bf3_result_if #(.SAMPLE_BITS(16)) res_ch ();
  bf3_cfg_if                        cfg_ch ();

  box_filter_3x3_mean #(
    .MAX_WIDTH   (MAX_W),
    .SAMPLE_BITS (16)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samp_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  // clock
  always #2 clk = ~clk;

  // filter state mirror
  logic [FRAME_WIDTH_BITS-1:0]  reg_width  = FRAME_WIDTH_RESET;
  logic [FRAME_HEIGHT_BITS-1:0] reg_height = FRAME_HEIGHT_RESET;
  logic signed [15:0] store_near [0:MAX_W-1] = '{default: '0};
  logic signed [15:0] store_far  [0:MAX_W-1] = '{default: '0};
  logic signed [15:0] win [0:2][0:1] = '{default: '0};
  int row_at = 0;
  int col_at = 0;

  pixel_t pixels_due [$];
  pixel_t due;

  int fail_count = 0;
  int rand_words = 0;
  int src_idle   = 0;
  int sink_idle  = 0;
  int stall_asks = 0;
  int stall_seen = 0;
  int hold_left  = 0;
  int quiet      = 0;

  task automatic report(input string what, input int row, input int col,
                        input longint got, input longint want);
    $display("mismatch %s at row %0d col %0d: got %0d want %0d", what, row, col, got, want);
    fail_count++;
  endtask

  task automatic emit_px(input logic signed [15:0] v, input int row, input int col,
                         input bit last);
    pixel_t p;
    p.value     = v;
    p.row       = row[ROW_BITS-1:0];
    p.col       = col[COL_TAG_BITS-1:0];
    p.frame_end = last;
    pixels_due = {pixels_due, p};
  endtask

  // advance the mirror by one sample word and queue the pixels it releases
  task automatic smooth_step(input logic signed [15:0] s, output int n);
    int w, h, r, c, ci, pr, pc;
    bit row_end, last_row;
    logic signed [15:0] top, mid, v;
    logic signed [19:0] sum;
    logic [19:0] mag, q;
    n = 0;
    w = int'(reg_width);
    h = int'(reg_height);
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (h < 1) h = 1;
    r = row_at;
    c = col_at;
    ci = (c < MAX_W) ? c : MAX_W - 1;
    row_end  = (c >= w - 1);
    last_row = (r >= h - 1);
    top = store_far[ci];
    mid = store_near[ci];

    // pixel one row up, one column left: mean if interior, else passed through
    if (r >= 1 && c >= 1) begin
      pr = r - 1;
      pc = c - 1;
      v = win[1][0];
      if (pr >= 1 && pr + 2 <= h && pc >= 1 && pc + 2 <= w) begin
        sum = 20'(top) + 20'(mid) + 20'(s) + 20'(win[0][0]) + 20'(win[0][1]) +
              20'(win[1][0]) + 20'(win[1][1]) + 20'(win[2][0]) + 20'(win[2][1]);
        mag = (sum < 0) ? -sum : sum;
        q = (mag + 20'd4) / 20'd9;
        v = (sum < 0) ? -q[15:0] : q[15:0];
      end
      emit_px(v, pr, pc, 1'b0);
      n++;
    end
    // right border of the row above
    if (r >= 1 && row_end) begin
      emit_px(mid, r - 1, c, 1'b0);
      n++;
    end
    // last row flushes itself
    if (last_row && c >= 1) begin
      emit_px(win[2][0], r, c - 1, 1'b0);
      n++;
    end
    if (last_row && row_end) begin
      emit_px(s, r, c, 1'b1);
      n++;
    end

    store_far[ci]  = mid;
    store_near[ci] = s;
    for (int k = 0; k < 3; k++) win[k][1] = win[k][0];
    win[0][0] = top;
    win[1][0] = mid;
    win[2][0] = s;
    if (row_end) begin
      col_at = 0;
      row_at = last_row ? 0 : ((r + 1) & 16'hFFFF);
    end else begin
      col_at = c + 1;
    end
  endtask

  // sample word handshake, with random gaps before the word
  task automatic offer_sample(input logic signed [15:0] s);
    while ($urandom_range(99, 0) < src_idle) begin
      samp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samp_ch.valid  <= 1'b1;
    samp_ch.sample <= s;
    @(posedge clk);
    while (!samp_ch.ready) @(posedge clk);
  endtask

  task automatic feed(input logic signed [15:0] s);
    int n;
    smooth_step(s, n);
    offer_sample(s);
  endtask

  // hold input until every pixel is out, then let the pipeline empty
  task automatic settle();
    samp_ch.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_FRAME_WIDTH)
      reg_width = val[FRAME_WIDTH_BITS-1:0];
    else
      reg_height = val;
  endtask

  task automatic resize(input logic [15:0] wd, input logic [15:0] hd);
    settle();
    write_reg(CFG_FRAME_WIDTH, wd);
    write_reg(CFG_FRAME_HEIGHT, hd);
    cfg_ch.valid <= 1'b0;
  endtask

  // idle pattern follows progress through the random part
  task automatic pick_mode();
    case (rand_words * 3 / RAND_WORDS)
      0: begin
        src_idle  = 18;
        sink_idle = 81;
      end
      1: begin
        src_idle  = 81;
        sink_idle = 18;
      end
      default: begin
        src_idle  = 0;
        sink_idle = 0;
      end
    endcase
  endtask

  function automatic logic signed [15:0] rand_sample();
    int t;
    case ($urandom_range(5, 0))
      0: begin
        case ($urandom_range(3, 0))
          0: t = 32767;
          1: t = -32768;
          2: t = 0;
          default: t = -1;
        endcase
      end
      1, 2: t = int'($urandom_range(40, 0)) - 20;
      default: t = $urandom();
    endcase
    return t[15:0];
  endfunction

  // whole frames of random words; junk_hi sets unused high bits of the width word
  task automatic run_frames(input int w, input int h, input int frames, input bit junk_hi);
    logic [15:0] wd;
    int ew, eh;
    wd = w[15:0];
    if (junk_hi) wd[15:11] = 5'($urandom_range(31, 1));
    ew = (w < 1) ? 1 : (w > MAX_W) ? MAX_W : w;
    eh = (h < 1) ? 1 : h;
    pick_mode();
    resize(wd, h[15:0]);
    repeat (frames * ew * eh) begin
      feed(rand_sample());
      rand_words++;
    end
  endtask

  // result receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_asks != stall_seen) begin
      stall_seen <= stall_asks;
      hold_left <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99, 0) >= sink_idle);
    end
  end

  // result check against the oldest queued pixel
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pixels_due.size() == 0) begin
        report("unexpected word", res_ch.out_row, res_ch.out_col, res_ch.value, 0);
      end else begin
        due = pixels_due.pop_front();
        if (res_ch.value !== due.value)
          report("value", due.row, due.col, res_ch.value, due.value);
        if (res_ch.out_row !== due.row)
          report("out_row", due.row, due.col, res_ch.out_row, due.row);
        if (res_ch.out_col !== due.col)
          report("out_col", due.row, due.col, res_ch.out_col, due.col);
        if (res_ch.frame_end !== due.frame_end)
          report("frame_end", due.row, due.col, res_ch.frame_end, due.frame_end);
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((samp_ch.valid && samp_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("box_filter_3x3_mean verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int n;
    samp_ch.valid  <= 1'b0;
    samp_ch.sample <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_FRAME_WIDTH;
    cfg_ch.data    <= '0;
    pick_mode();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed frames: all-max, all-min, and a single pixel frame from zero sizes
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_SIZE) begin
        resize(PLAN[i].a[15:0], PLAN[i].b[15:0]);
      end else begin
        for (int k = 0; k < PLAN[i].times; k++) begin
          smooth_step(PLAN[i].a[15:0], n);
          if (PLAN[i].known && k == PLAN[i].times - 1)
            pixels_due[pixels_due.size() - n].value = PLAN[i].want;
          offer_sample(PLAN[i].a[15:0]);
        end
      end
    end

    // single column: every word ends a row
    run_frames(1, 5, 2, 1'b0);
    // single row: every word is in the last row
    run_frames(7, 1, 2, 1'b0);
    // long receiver hold-off while words keep coming
    stall_asks++;
    run_frames(6, 5, 1, 1'b0);

    // tallest frame, cut short by shrinking both sizes while it is open
    resize(16'd8, 16'hFFFF);
    repeat (27) begin
      feed(rand_sample());
      rand_words++;
    end
    resize(16'd4, 16'd0);
    feed(rand_sample());
    rand_words++;

    // random frame sizes, mostly small
    while (rand_words < RAND_WORDS) begin
      run_frames(($urandom_range(3, 0) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1),
                 $urandom_range(6, 1), 1, $urandom_range(3, 0) == 0);
    end

    settle();
    if (fail_count == 0)
      $display("box_filter_3x3_mean verification clean");
    else
      $display("box_filter_3x3_mean verification failed");
    $finish;
  end

endmodule
